FILE: sv/qlet_pkg.sv
// Shared types, constants and helper functions for the quorum leader election tick block.
package qlet_pkg;

    // Peer population and timing
    localparam int PEER_COUNT = 32;
    localparam int TICK_MS    = 10;

    // Field widths
    localparam int MASK_W     = 32;
    localparam int ID_W       = 5;
    localparam int CNT_W      = 6;
    localparam int HOLD_W     = 16;
    localparam int REC_W      = 17;
    localparam int CAP_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Queue sizing (power of two)
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Peers that exist in this swarm
    localparam logic [MASK_W-1:0] PEER_RANGE = {MASK_W{1'b1}} >> (MASK_W - PEER_COUNT);

    // Capability flag positions
    localparam int CAP_RELAY    = 0;
    localparam int CAP_SENSOR   = 1;
    localparam int CAP_ACTUATOR = 2;

    typedef enum logic [1:0] {
        Q_LOST     = 2'd0,
        Q_DEGRADED = 2'd1,
        Q_HEALTHY  = 2'd2
    } t_quorum;

    typedef enum logic [1:0] {
        AB_NONE      = 2'd0,
        AB_TRIGGERED = 2'd1,
        AB_CLEARED   = 2'd2
    } t_abort;

    typedef enum logic [2:0] {
        ROLE_NONE     = 3'd0,
        ROLE_LEADER   = 3'd1,
        ROLE_RELAY    = 3'd2,
        ROLE_SENSOR   = 3'd3,
        ROLE_ACTUATOR = 3'd4,
        ROLE_FOLLOWER = 3'd5
    } t_role;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ID        = 3'd0,
        CFG_QUORUM_MIN    = 3'd1,
        CFG_QUORUM_TARGET = 3'd2,
        CFG_CAPABILITY    = 3'd3,
        CFG_HOLD_MS       = 3'd4,
        CFG_WHITELIST     = 3'd5,
        CFG_ANOMALY       = 3'd6
    } t_cfg_idx;

    // Input word: one tick
    typedef struct packed {
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] stale_mask;
        logic [MASK_W-1:0] departed_mask;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0]       quorum_level;
        logic [1:0]       abort_signal;
        logic [ID_W-1:0]  fresh_peers;
        logic             lead_ok;
        logic [ID_W-1:0]  lead_id;
        logic [2:0]       role;
        logic [ID_W-1:0]  rank_slot;
        logic [CNT_W-1:0] group_size;
    } t_out_word;

    // Classified tick passed from front to back
    typedef struct packed {
        logic [MASK_W-1:0] fresh_mask;
        logic [CNT_W-1:0]  n_fresh;
        logic              vacuous;
    } t_cls_word;

    // Settings seen by the front
    typedef struct packed {
        logic [ID_W-1:0]   own_id;
        logic [MASK_W-1:0] whitelist_mask;
        logic [MASK_W-1:0] suspect_mask;
    } t_front_cfg;

    // Settings seen by the back
    typedef struct packed {
        logic [ID_W-1:0]   own_id;
        logic [CNT_W-1:0]  degrade_floor;
        logic [CNT_W-1:0]  healthy_floor;
        logic [CAP_W-1:0]  capability_bits;
        logic [HOLD_W-1:0] hold_ms;
    } t_back_cfg;

    // Population count of a peer mask
    function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

FILE: sv/qlet_front.sv
// Front end: accepts ticks, derives trusted fresh peers and counts, one register stage.
module qlet_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  qlet_pkg::t_in_word    i_item_word,
    input  qlet_pkg::t_front_cfg  i_cfg,
    input  logic                  i_q_ready,
    output logic                  o_cls_valid,
    output qlet_pkg::t_cls_word   o_cls_word
);

    logic                            r_vld;
    logic                            n_vld;
    qlet_pkg::t_cls_word             r_cls;
    qlet_pkg::t_cls_word             cls;
    logic [qlet_pkg::MASK_W-1:0]     self_bit;
    logic [qlet_pkg::MASK_W-1:0]     trusted;
    logic [qlet_pkg::MASK_W-1:0]     known;
    logic [qlet_pkg::MASK_W-1:0]     dep;
    logic                            take;

    // Trust filter and peer classification
    always_comb begin
        if (int'(i_cfg.own_id) < qlet_pkg::PEER_COUNT) begin
            self_bit = qlet_pkg::MASK_W'(1) << i_cfg.own_id;
        end else begin
            self_bit = '0;
        end
        trusted = qlet_pkg::PEER_RANGE & ~self_bit & ~i_cfg.suspect_mask;
        if (i_cfg.whitelist_mask != '0) begin
            trusted = trusted & i_cfg.whitelist_mask;
        end
        known          = trusted & i_item_word.active_mask;
        dep            = known & i_item_word.departed_mask;
        cls.fresh_mask = known & ~i_item_word.departed_mask & ~i_item_word.stale_mask;
        cls.n_fresh    = qlet_pkg::popcount(cls.fresh_mask);
        // every known peer departed, and at least one did
        cls.vacuous    = (dep != '0) && ((known & ~i_item_word.departed_mask) == '0);
    end

    // Stage handshake
    assign full        = r_vld && !i_q_ready;
    assign take        = push && !full;
    assign o_cls_valid = r_vld;
    assign o_cls_word  = r_cls;

    always_comb begin
        if (take) begin
            n_vld = 1'b1;
        end else if (i_q_ready) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls <= cls;
        end
    end

endmodule

FILE: sv/qlet_cls_q.sv
// Short queue of classified ticks between the front and the back.
module qlet_cls_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qlet_pkg::t_cls_word  i_word,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output qlet_pkg::t_cls_word  o_head
);

    qlet_pkg::t_cls_word                 r_mem [qlet_pkg::Q_DEPTH];
    logic [qlet_pkg::Q_PTR_W-1:0]        r_wptr;
    logic [qlet_pkg::Q_PTR_W-1:0]        r_rptr;
    logic [qlet_pkg::Q_CNT_W-1:0]        r_cnt;
    logic [qlet_pkg::Q_CNT_W-1:0]        n_cnt;
    logic                                wr_en;
    logic                                rd_en;

    assign o_ready = (r_cnt != qlet_pkg::Q_CNT_W'(qlet_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!wr_en && rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= qlet_pkg::Q_CNT_W'(qlet_pkg::Q_DEPTH))
        else $error("classified queue overfilled");

endmodule

FILE: sv/qlet_back.sv
// Back end: quorum state, recovery hold, abort tracking, election and result queue.
module qlet_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  qlet_pkg::t_cls_word  i_head,
    output logic                 o_head_pop,
    input  qlet_pkg::t_back_cfg  i_cfg,
    output logic                 empty,
    input  logic                 pop,
    output qlet_pkg::t_out_word  o_res_word
);

    qlet_pkg::t_quorum                   r_last;
    qlet_pkg::t_quorum                   raw;
    qlet_pkg::t_quorum                   level;
    qlet_pkg::t_abort                    r_abort;
    qlet_pkg::t_abort                    n_abort;
    qlet_pkg::t_role                     role;
    logic [qlet_pkg::REC_W-1:0]          r_rec;
    logic [qlet_pkg::REC_W-1:0]          n_rec;
    logic [qlet_pkg::REC_W-1:0]          rec_t;
    logic [qlet_pkg::REC_W-1:0]          hold_ext;
    logic [qlet_pkg::ID_W-1:0]           first_id;
    logic                                found;
    logic [qlet_pkg::ID_W-1:0]           leader;
    logic [qlet_pkg::MASK_W-1:0]         below;
    logic [qlet_pkg::CNT_W-1:0]          slot_cnt;
    qlet_pkg::t_out_word                 res;
    logic                                fire;

    qlet_pkg::t_out_word                 r_omem [qlet_pkg::Q_DEPTH];
    logic [qlet_pkg::Q_PTR_W-1:0]        r_owptr;
    logic [qlet_pkg::Q_PTR_W-1:0]        r_orptr;
    logic [qlet_pkg::Q_CNT_W-1:0]        r_ocnt;
    logic [qlet_pkg::Q_CNT_W-1:0]        n_ocnt;
    logic                                out_space;
    logic                                out_rd;

    assign out_space  = (r_ocnt != qlet_pkg::Q_CNT_W'(qlet_pkg::Q_DEPTH));
    assign fire       = i_head_valid && out_space;
    assign o_head_pop = fire;

    // Raw quorum from the fresh count; healthy when every known peer departed
    always_comb begin
        if (i_head.n_fresh >= i_cfg.healthy_floor) begin
            raw = qlet_pkg::Q_HEALTHY;
        end else if (i_head.n_fresh >= i_cfg.degrade_floor) begin
            raw = qlet_pkg::Q_DEGRADED;
        end else begin
            raw = qlet_pkg::Q_LOST;
        end
        if (i_head.vacuous) begin
            raw = qlet_pkg::Q_HEALTHY;
        end
    end

    // Recovery hold out of lost
    always_comb begin
        hold_ext = qlet_pkg::REC_W'(i_cfg.hold_ms);
        level    = raw;
        n_rec    = r_rec;
        rec_t    = r_rec;
        if (i_cfg.hold_ms != '0) begin
            if (raw == qlet_pkg::Q_LOST) begin
                n_rec = '0;
            end else if (r_last == qlet_pkg::Q_LOST) begin
                if (r_rec < hold_ext) begin
                    rec_t = r_rec + qlet_pkg::REC_W'(qlet_pkg::TICK_MS);
                end
                if (rec_t < hold_ext) begin
                    level = qlet_pkg::Q_LOST;
                    n_rec = rec_t;
                end else begin
                    n_rec = '0;
                end
            end
        end
    end

    // Abort trigger and one-tick clear
    always_comb begin
        n_abort = r_abort;
        if (r_abort == qlet_pkg::AB_CLEARED) begin
            n_abort = qlet_pkg::AB_NONE;
        end
        if (r_last != qlet_pkg::Q_LOST && level == qlet_pkg::Q_LOST) begin
            n_abort = qlet_pkg::AB_TRIGGERED;
        end else if (n_abort == qlet_pkg::AB_TRIGGERED && r_last == qlet_pkg::Q_LOST
                     && level != qlet_pkg::Q_LOST) begin
            n_abort = qlet_pkg::AB_CLEARED;
        end
    end

    // Lowest fresh peer id, leader choice and rank slot
    always_comb begin
        first_id = '0;
        found    = 1'b0;
        for (int i = qlet_pkg::MASK_W - 1; i >= 0; i--) begin
            if (i_head.fresh_mask[i]) begin
                first_id = qlet_pkg::ID_W'(i);
                found    = 1'b1;
            end
        end
        leader = i_cfg.own_id;
        if (found && first_id < i_cfg.own_id) begin
            leader = first_id;
        end
        below    = i_head.fresh_mask & ((qlet_pkg::MASK_W'(1) << i_cfg.own_id) - 1'b1);
        slot_cnt = qlet_pkg::popcount(below);
    end

    // Role choice
    always_comb begin
        if (leader == i_cfg.own_id) begin
            role = qlet_pkg::ROLE_LEADER;
        end else if (i_cfg.capability_bits[qlet_pkg::CAP_RELAY]) begin
            role = qlet_pkg::ROLE_RELAY;
        end else if (i_cfg.capability_bits[qlet_pkg::CAP_SENSOR]) begin
            role = qlet_pkg::ROLE_SENSOR;
        end else if (i_cfg.capability_bits[qlet_pkg::CAP_ACTUATOR]) begin
            role = qlet_pkg::ROLE_ACTUATOR;
        end else begin
            role = qlet_pkg::ROLE_FOLLOWER;
        end
    end

    // Result word assembly
    always_comb begin
        res.quorum_level = level;
        res.abort_signal = n_abort;
        res.fresh_peers  = i_head.n_fresh[qlet_pkg::ID_W-1:0];
        if (level == qlet_pkg::Q_LOST) begin
            res.lead_ok    = 1'b0;
            res.lead_id    = '0;
            res.role       = qlet_pkg::ROLE_NONE;
            res.rank_slot  = '0;
            res.group_size = '0;
        end else begin
            res.lead_ok    = 1'b1;
            res.lead_id    = leader;
            res.role       = role;
            res.rank_slot  = slot_cnt[qlet_pkg::ID_W-1:0];
            res.group_size = i_head.n_fresh + 1'b1;
        end
    end

    // Quorum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= qlet_pkg::Q_LOST;
            r_rec   <= '0;
            r_abort <= qlet_pkg::AB_NONE;
        end else if (fire) begin
            r_last  <= level;
            r_rec   <= n_rec;
            r_abort <= n_abort;
        end
    end

    // Result queue
    assign empty      = (r_ocnt == '0);
    assign out_rd     = pop && !empty;
    assign o_res_word = r_omem[r_orptr];

    always_comb begin
        n_ocnt = r_ocnt;
        if (fire && !out_rd) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (!fire && out_rd) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr <= '0;
            r_orptr <= '0;
            r_ocnt  <= '0;
        end else begin
            if (fire) begin
                r_owptr <= r_owptr + 1'b1;
            end
            if (out_rd) begin
                r_orptr <= r_orptr + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_omem[r_owptr] <= res;
        end
    end

    a_clear_after_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.abort_signal == qlet_pkg::AB_CLEARED) |-> (r_abort == qlet_pkg::AB_TRIGGERED))
        else $error("abort cleared without a prior trigger");

    a_group_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.quorum_level != qlet_pkg::Q_LOST)
            |-> (res.group_size == qlet_pkg::CNT_W'(res.fresh_peers) + 1'b1))
        else $error("group size does not match fresh peer count");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= qlet_pkg::Q_CNT_W'(qlet_pkg::Q_DEPTH))
        else $error("result queue overfilled");

endmodule

FILE: sv/quorum_leader_election_tick.sv
// Top level: configuration registers, front classifier, middle queue and back end.
// Flow: an accepted tick is registered in the front stage, then taken by the
// two-entry middle queue, then by the two-entry result queue that drives the result ports.
// Throughput: one tick per cycle unless full; full/empty follow the middle/result queues.
// Reset: synchronous active low; clears queues, quorum state (lost), recovery time,
// abort status (none) and all configuration registers to zero.
module quorum_leader_election_tick (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  qlet_pkg::t_in_word                i_item_word,
    output logic                              empty,
    input  logic                              pop,
    output qlet_pkg::t_out_word               o_res_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qlet_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qlet_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [qlet_pkg::ID_W-1:0]    r_own_id;
    logic [qlet_pkg::CNT_W-1:0]   r_degrade_floor;
    logic [qlet_pkg::CNT_W-1:0]   r_healthy_floor;
    logic [qlet_pkg::CAP_W-1:0]   r_capability;
    logic [qlet_pkg::HOLD_W-1:0]  r_hold_ms;
    logic [qlet_pkg::MASK_W-1:0]  r_whitelist;
    logic [qlet_pkg::MASK_W-1:0]  r_anomaly;

    qlet_pkg::t_front_cfg         front_cfg;
    qlet_pkg::t_back_cfg          back_cfg;
    logic                         cls_valid;
    qlet_pkg::t_cls_word          cls_word;
    logic                         q_ready;
    logic                         q_valid;
    qlet_pkg::t_cls_word          q_head;
    logic                         q_pop;

    // Configuration register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id        <= '0;
            r_degrade_floor <= '0;
            r_healthy_floor <= '0;
            r_capability    <= '0;
            r_hold_ms       <= '0;
            r_whitelist     <= '0;
            r_anomaly       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qlet_pkg::CFG_OWN_ID:        r_own_id        <= i_cfg_data[qlet_pkg::ID_W-1:0];
                qlet_pkg::CFG_QUORUM_MIN:    r_degrade_floor <= i_cfg_data[qlet_pkg::CNT_W-1:0];
                qlet_pkg::CFG_QUORUM_TARGET: r_healthy_floor <= i_cfg_data[qlet_pkg::CNT_W-1:0];
                qlet_pkg::CFG_CAPABILITY:    r_capability    <= i_cfg_data[qlet_pkg::CAP_W-1:0];
                qlet_pkg::CFG_HOLD_MS:       r_hold_ms       <= i_cfg_data[qlet_pkg::HOLD_W-1:0];
                qlet_pkg::CFG_WHITELIST:     r_whitelist     <= i_cfg_data[qlet_pkg::MASK_W-1:0];
                qlet_pkg::CFG_ANOMALY:       r_anomaly       <= i_cfg_data[qlet_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        front_cfg.own_id          = r_own_id;
        front_cfg.whitelist_mask  = r_whitelist;
        front_cfg.suspect_mask    = r_anomaly;
        back_cfg.own_id           = r_own_id;
        back_cfg.degrade_floor    = r_degrade_floor;
        back_cfg.healthy_floor    = r_healthy_floor;
        back_cfg.capability_bits  = r_capability;
        back_cfg.hold_ms          = r_hold_ms;
    end

    qlet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item_word (i_item_word),
        .i_cfg       (front_cfg),
        .i_q_ready   (q_ready),
        .o_cls_valid (cls_valid),
        .o_cls_word  (cls_word)
    );

    qlet_cls_q u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cls_valid),
        .i_word  (cls_word),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    qlet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_head_pop   (q_pop),
        .i_cfg        (back_cfg),
        .empty        (empty),
        .pop          (pop),
        .o_res_word   (o_res_word)
    );

endmodule

FILE: verif/tb_quorum_leader_election_tick.sv
// Self-checking testbench for quorum_leader_election_tick: directed and random ticks, scoreboard.
module tb_quorum_leader_election_tick;
    timeunit 1ns;
    timeprecision 1ps;

    // Index past the register list; writes to it must be dropped
    localparam logic [qlet_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam logic [qlet_pkg::MASK_W-1:0]    ALL_PEERS     = {qlet_pkg::MASK_W{1'b1}};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    qlet_pkg::t_in_word              i_item_word = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    qlet_pkg::t_out_word             o_res_word;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [qlet_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [qlet_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    quorum_leader_election_tick u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item_word (i_item_word),
        .empty       (empty),
        .pop         (pop),
        .o_res_word  (o_res_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Ticks waiting to be pushed, and status words waiting to be popped
    qlet_pkg::t_in_word  tick_backlog[$];
    qlet_pkg::t_out_word status_expected[$];
    int        mismatch_cnt = 0;
    int        send_idle = 18;
    int        recv_idle = 85;

    // Shadow of the settings registers
    logic [qlet_pkg::ID_W-1:0]   sh_own_id = '0;
    logic [qlet_pkg::CNT_W-1:0]  sh_qmin = '0;
    logic [qlet_pkg::CNT_W-1:0]  sh_qtarget = '0;
    logic [qlet_pkg::CAP_W-1:0]  sh_cap = '0;
    logic [qlet_pkg::HOLD_W-1:0] sh_hold = '0;
    logic [qlet_pkg::MASK_W-1:0] sh_whitelist = '0;
    logic [qlet_pkg::MASK_W-1:0] sh_anomaly = '0;

    // Quorum state carried from tick to tick
    qlet_pkg::t_quorum          last_lvl = qlet_pkg::Q_LOST;
    logic [qlet_pkg::REC_W-1:0] rec_ms = '0;
    qlet_pkg::t_abort           abort_st = qlet_pkg::AB_NONE;

    // Work out the status word one tick produces and advance the quorum state
    task automatic elect_tick(input qlet_pkg::t_in_word w, output qlet_pkg::t_out_word r);
        logic [qlet_pkg::MASK_W-1:0] trusted, known, dep, fresh;
        int      n_known, n_dep, n_fresh, leader, slot;
        qlet_pkg::t_quorum raw, lvl;
        qlet_pkg::t_role   rl;
        trusted = ~(32'd1 << sh_own_id) & ~sh_anomaly;
        if (sh_whitelist != '0) begin
            trusted = trusted & sh_whitelist;
        end
        known   = trusted & w.active_mask;
        dep     = known & w.departed_mask;
        fresh   = known & ~w.departed_mask & ~w.stale_mask;
        n_known = $countones(known);
        n_dep   = $countones(dep);
        n_fresh = $countones(fresh);

        // raw level from the fresh count; all known peers departed reads healthy
        if (n_fresh >= sh_qtarget) raw = qlet_pkg::Q_HEALTHY;
        else if (n_fresh >= sh_qmin) raw = qlet_pkg::Q_DEGRADED;
        else raw = qlet_pkg::Q_LOST;
        if (n_dep > 0 && n_known == n_dep) raw = qlet_pkg::Q_HEALTHY;

        // recovery hold out of lost
        lvl = raw;
        if (sh_hold != '0) begin
            if (raw == qlet_pkg::Q_LOST) begin
                rec_ms = '0;
            end else if (last_lvl == qlet_pkg::Q_LOST) begin
                if (rec_ms < sh_hold) rec_ms = rec_ms + qlet_pkg::REC_W'(qlet_pkg::TICK_MS);
                if (rec_ms < sh_hold) lvl = qlet_pkg::Q_LOST;
                else rec_ms = '0;
            end
        end

        // abort: trigger on falling into lost, clear for one tick on leaving it
        if (abort_st == qlet_pkg::AB_CLEARED) abort_st = qlet_pkg::AB_NONE;
        if (last_lvl != qlet_pkg::Q_LOST && lvl == qlet_pkg::Q_LOST) begin
            abort_st = qlet_pkg::AB_TRIGGERED;
        end else if (abort_st == qlet_pkg::AB_TRIGGERED && last_lvl == qlet_pkg::Q_LOST
                     && lvl != qlet_pkg::Q_LOST) begin
            abort_st = qlet_pkg::AB_CLEARED;
        end
        last_lvl = lvl;

        r = '0;
        r.quorum_level = lvl;
        r.abort_signal = abort_st;
        r.fresh_peers  = n_fresh[qlet_pkg::ID_W-1:0];
        if (lvl != qlet_pkg::Q_LOST) begin
            leader = sh_own_id;
            for (int i = qlet_pkg::MASK_W - 1; i >= 0; i--) begin
                if (fresh[i] && i < leader) leader = i;
            end
            slot = $countones(fresh & ((32'd1 << sh_own_id) - 32'd1));
            if (leader == sh_own_id) rl = qlet_pkg::ROLE_LEADER;
            else if (sh_cap[qlet_pkg::CAP_RELAY]) rl = qlet_pkg::ROLE_RELAY;
            else if (sh_cap[qlet_pkg::CAP_SENSOR]) rl = qlet_pkg::ROLE_SENSOR;
            else if (sh_cap[qlet_pkg::CAP_ACTUATOR]) rl = qlet_pkg::ROLE_ACTUATOR;
            else rl = qlet_pkg::ROLE_FOLLOWER;
            r.lead_ok    = 1'b1;
            r.lead_id    = leader[qlet_pkg::ID_W-1:0];
            r.role       = rl;
            r.rank_slot  = slot[qlet_pkg::ID_W-1:0];
            r.group_size = qlet_pkg::CNT_W'(n_fresh + 1);
        end
    endtask

    // Tick driver: push from the backlog, predict on acceptance
    always @(posedge i_clk) begin
        qlet_pkg::t_out_word want;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                elect_tick(i_item_word, want);
                status_expected.push_back(want);
                void'(tick_backlog.pop_front());
            end
            if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
                push        <= 1'b1;
                i_item_word <= tick_backlog[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Status monitor: pop at random, compare against the oldest prediction
    always @(posedge i_clk) begin
        qlet_pkg::t_out_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (status_expected.size() == 0) begin
                    $error("status word popped with no tick outstanding");
                    mismatch_cnt++;
                end else begin
                    want = status_expected.pop_front();
                    check_field("quorum_level", want.quorum_level, o_res_word.quorum_level);
                    check_field("abort_signal", want.abort_signal, o_res_word.abort_signal);
                    check_field("fresh_peers", want.fresh_peers, o_res_word.fresh_peers);
                    check_field("lead_ok", want.lead_ok, o_res_word.lead_ok);
                    check_field("lead_id", want.lead_id, o_res_word.lead_id);
                    check_field("role", want.role, o_res_word.role);
                    check_field("rank_slot", want.rank_slot, o_res_word.rank_slot);
                    check_field("group_size", want.group_size, o_res_word.group_size);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Settings write; the shadow follows only for indexes in the register list
    task automatic cfg_write(input logic [qlet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qlet_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            qlet_pkg::CFG_OWN_ID:        sh_own_id    = data[qlet_pkg::ID_W-1:0];
            qlet_pkg::CFG_QUORUM_MIN:    sh_qmin      = data[qlet_pkg::CNT_W-1:0];
            qlet_pkg::CFG_QUORUM_TARGET: sh_qtarget   = data[qlet_pkg::CNT_W-1:0];
            qlet_pkg::CFG_CAPABILITY:    sh_cap       = data[qlet_pkg::CAP_W-1:0];
            qlet_pkg::CFG_HOLD_MS:       sh_hold      = data[qlet_pkg::HOLD_W-1:0];
            qlet_pkg::CFG_WHITELIST:     sh_whitelist = data;
            qlet_pkg::CFG_ANOMALY:       sh_anomaly   = data;
            default: ;
        endcase
    endtask

    // Block until every queued tick has been pushed and every status word popped
    task automatic wait_drained();
        while (tick_backlog.size() != 0 || status_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic add_tick(input logic [qlet_pkg::MASK_W-1:0] a,
                            input logic [qlet_pkg::MASK_W-1:0] s,
                            input logic [qlet_pkg::MASK_W-1:0] d);
        qlet_pkg::t_in_word w;
        w.active_mask   = a;
        w.stale_mask    = s;
        w.departed_mask = d;
        tick_backlog.push_back(w);
    endtask

    function automatic logic [qlet_pkg::MASK_W-1:0] bit_density(input int pct);
        logic [qlet_pkg::MASK_W-1:0] m;
        for (int i = 0; i < qlet_pkg::MASK_W; i++) begin
            m[i] = ($urandom_range(99) < pct);
        end
        return m;
    endfunction

    // Random tick around a batch density; some ticks have every known peer departed
    task automatic add_random_tick(input int base_pct);
        logic [qlet_pkg::MASK_W-1:0] a, s, d;
        int pa;
        pa = base_pct + int'($urandom_range(30)) - 15;
        case ($urandom_range(9))
            0: begin
                a = $urandom; s = $urandom; d = $urandom;
            end
            1: begin
                a = bit_density(pa); s = bit_density(20); d = a | $urandom;
            end
            2: begin
                a = bit_density(pa); s = '0; d = '0;
            end
            default: begin
                a = bit_density(pa);
                s = bit_density(int'($urandom_range(25)));
                d = bit_density(int'($urandom_range(15)));
            end
        endcase
        add_tick(a, s, d);
    endtask

    // New random settings for a batch, extremes included
    task automatic roll_settings();
        logic [qlet_pkg::CNT_W-1:0]  qbase, qmin, qtgt;
        logic [qlet_pkg::HOLD_W-1:0] hold;
        logic [qlet_pkg::MASK_W-1:0] wl, an;
        logic [qlet_pkg::ID_W-1:0]   own;
        case ($urandom_range(3))
            0: own = '0;
            1: own = '1;
            default: own = qlet_pkg::ID_W'($urandom_range(31));
        endcase
        qbase = qlet_pkg::CNT_W'($urandom_range(12));
        qmin  = ($urandom_range(9) == 0) ? qlet_pkg::CNT_W'($urandom_range(33, 63)) : qbase;
        case ($urandom_range(9))
            0: qtgt = 6'd63;
            1: qtgt = 6'd32;
            default: qtgt = qbase + qlet_pkg::CNT_W'($urandom_range(10));
        endcase
        case ($urandom_range(5))
            0, 1: hold = '0;
            2: hold = qlet_pkg::HOLD_W'(qlet_pkg::TICK_MS);
            3, 4: hold = qlet_pkg::HOLD_W'(qlet_pkg::TICK_MS * $urandom_range(1, 8)
                                           + $urandom_range(9));
            default: hold = $urandom_range(1) ? '1 : qlet_pkg::HOLD_W'($urandom_range(300));
        endcase
        case ($urandom_range(3))
            0: wl = '0;
            1: wl = ALL_PEERS;
            2: wl = $urandom;
            default: wl = $urandom | $urandom;
        endcase
        case ($urandom_range(5))
            0, 1, 2: an = '0;
            3: an = $urandom & $urandom & $urandom;
            4: an = $urandom;
            default: an = ALL_PEERS;
        endcase
        cfg_write(qlet_pkg::CFG_OWN_ID, qlet_pkg::CFG_DATA_W'(own));
        cfg_write(qlet_pkg::CFG_QUORUM_MIN, qlet_pkg::CFG_DATA_W'(qmin));
        cfg_write(qlet_pkg::CFG_QUORUM_TARGET, qlet_pkg::CFG_DATA_W'(qtgt));
        cfg_write(qlet_pkg::CFG_CAPABILITY, qlet_pkg::CFG_DATA_W'($urandom_range(7)));
        cfg_write(qlet_pkg::CFG_HOLD_MS, qlet_pkg::CFG_DATA_W'(hold));
        cfg_write(qlet_pkg::CFG_WHITELIST, wl);
        cfg_write(qlet_pkg::CFG_ANOMALY, an);
    endtask

    // Main sequence
    initial begin
        int dens;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // moderate thresholds, relay capability, no hold, everyone trusted
        cfg_write(qlet_pkg::CFG_OWN_ID, 32'd5);
        cfg_write(qlet_pkg::CFG_QUORUM_MIN, 32'd3);
        cfg_write(qlet_pkg::CFG_QUORUM_TARGET, 32'd6);
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd1);
        cfg_write(qlet_pkg::CFG_HOLD_MS, 32'd0);
        cfg_write(qlet_pkg::CFG_WHITELIST, 32'd0);
        cfg_write(qlet_pkg::CFG_ANOMALY, 32'd0);
        add_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        add_tick(ALL_PEERS, ALL_PEERS, 32'h0000_0000);      // all stale: lost, abort
        add_tick(ALL_PEERS, 32'h0000_0000, ALL_PEERS);      // all departed: healthy
        add_tick(32'h0000_0007, 32'h0000_0000, 32'h0000_0000);
        add_tick(32'h0000_00C0, 32'h0000_0000, 32'h0000_0000);
        add_tick(32'h0000_0020, 32'h0000_0000, 32'h0000_0000); // self bit only
        add_tick(32'h0000_FC00, 32'h0000_0000, 32'h0000_0000); // self leads
        add_tick(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        add_tick(ALL_PEERS, 32'hFFFF_FFFE, 32'h0000_0001);
        wait_drained();

        // thresholds beyond the swarm, 30 ms hold, whitelist and anomaly in play
        cfg_write(CFG_SPARE_IDX, 32'hFFFF_FFFF);
        cfg_write(qlet_pkg::CFG_OWN_ID, 32'd31);
        cfg_write(qlet_pkg::CFG_QUORUM_MIN, 32'd40);
        cfg_write(qlet_pkg::CFG_QUORUM_TARGET, 32'd63);
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd2);
        cfg_write(qlet_pkg::CFG_HOLD_MS, 32'd30);
        cfg_write(qlet_pkg::CFG_WHITELIST, 32'h0000_FFFF);
        cfg_write(qlet_pkg::CFG_ANOMALY, 32'h0000_0101);
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        repeat (3) add_tick(ALL_PEERS, 32'h0000_0000, ALL_PEERS); // held, then released
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        add_tick(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // longest hold: recovery stays held
        cfg_write(qlet_pkg::CFG_OWN_ID, 32'd0);
        cfg_write(qlet_pkg::CFG_QUORUM_MIN, 32'd0);
        cfg_write(qlet_pkg::CFG_QUORUM_TARGET, 32'd32);
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd4);
        cfg_write(qlet_pkg::CFG_HOLD_MS, 32'h0000_FFFF);
        cfg_write(qlet_pkg::CFG_WHITELIST, ALL_PEERS);
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        add_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // every peer anomalous
        cfg_write(qlet_pkg::CFG_HOLD_MS, 32'd0);
        cfg_write(qlet_pkg::CFG_QUORUM_MIN, 32'd1);
        cfg_write(qlet_pkg::CFG_QUORUM_TARGET, 32'd31);
        cfg_write(qlet_pkg::CFG_ANOMALY, ALL_PEERS);
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        cfg_write(qlet_pkg::CFG_ANOMALY, 32'd0);
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd6);
        add_tick(ALL_PEERS, 32'h0000_0000, 32'h0000_0000);
        add_tick(32'h0000_0002, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // highest own id, actuator only: a lower peer leads
        cfg_write(qlet_pkg::CFG_OWN_ID, 32'd31);
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd4);
        add_tick(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        wait_drained();
        cfg_write(qlet_pkg::CFG_CAPABILITY, 32'd0);
        add_tick(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);

        // random batches; each settings change waits for the block to drain
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            case (ph)
                0: begin send_idle = 18; recv_idle = 85; end
                1: begin send_idle = 85; recv_idle = 18; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int b = 0; b < 5; b++) begin
                wait_drained();
                roll_settings();
                dens = int'($urandom_range(30, 100));
                repeat (50) add_random_tick(dens);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("** quorum_leader_election_tick: PASSED **");
        end else begin
            $display("** quorum_leader_election_tick: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("** quorum_leader_election_tick: FAILED **");
        $finish;
    end

endmodule

FILE: quorum_leader_election_tick.f
sv/qlet_pkg.sv
sv/qlet_front.sv
sv/qlet_cls_q.sv
sv/qlet_back.sv
sv/quorum_leader_election_tick.sv
verif/tb_quorum_leader_election_tick.sv
